// ===== rtl/xcnl_pkg.sv =====
// Shared types and constants for the XOR-closest node list.
package xcnl_pkg;

   localparam int DEF_LIST_DEPTH = 8;
   localparam int DUMP_MAX       = 8;
   localparam int TARGET_W       = 160;

   localparam logic [7:0] NODE_FAIL_LIMIT = 8'd2;

   // request modes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_OFFER = 2'd1;
   localparam logic [1:0] MODE_DUMP  = 2'd2;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   // result status codes
   localparam logic [2:0] STAT_INSERTED  = 3'd0;
   localparam logic [2:0] STAT_DUPLICATE = 3'd1;
   localparam logic [2:0] STAT_TOO_FAR   = 3'd2;
   localparam logic [2:0] STAT_BAD_NODE  = 3'd3;
   localparam logic [2:0] STAT_DONE      = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_TARGET_HI  = 2'd0;
   localparam logic [1:0] CSR_TARGET_MID = 2'd1;
   localparam logic [1:0] CSR_TARGET_LO  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] node_id_hi;
      logic [63:0] node_id_mid;
      logic [31:0] node_id_lo;
      logic [31:0] node_addr;
      logic [15:0] node_port;
      logic [7:0]  fail_count;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [2:0]  position;
      logic [3:0]  count;
      logic [63:0] entry_id_hi;
      logic [63:0] entry_id_mid;
      logic [31:0] entry_id_lo;
      logic [31:0] entry_addr;
      logic [15:0] entry_port;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] id_hi;
      logic [63:0] id_mid;
      logic [31:0] id_lo;
      logic [31:0] addr;
      logic [15:0] port;
   } entry_type;

   // first-hit scan carried along the chain
   typedef struct packed {
      logic found;
      logic dup;
   } scan_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_CMP,
      OP_INSERT,
      OP_ROTATE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_EXEC,
      ST_DUMP
   } state_type;

endpackage

// ===== rtl/xcnl_cell.sv =====
// One list slot: holds an entry, compares it with the offered node, shifts and rotates.
module xcnl_cell
   import xcnl_pkg::*;
#(
   parameter int IDX_W    = 3,
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  cell_op_type         op,
   input  logic [TARGET_W-1:0] target,
   input  entry_type           node,
   input  logic                occ,
   input  entry_type           prev_entry,
   input  entry_type           next_entry,
   input  scan_type            scan_in,
   input  logic [IDX_W-1:0]    pos_in,
   output scan_type            scan_out,
   output logic [IDX_W-1:0]    pos_out,
   output entry_type           entry
);

   entry_type           slot_ff, slot_in;
   logic                lt_ff, lt_in;
   logic                eq_ff, eq_in;
   logic [TARGET_W-1:0] node_dist;
   logic [TARGET_W-1:0] slot_dist;
   logic                hit;

   assign node_dist = {node.id_hi, node.id_mid, node.id_lo} ^ target;
   assign slot_dist = {slot_ff.id_hi, slot_ff.id_mid, slot_ff.id_lo} ^ target;

   // an empty slot always counts as a hit
   assign hit = !occ || lt_ff || eq_ff;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (op == OP_CMP) begin
         lt_in = node_dist < slot_dist;
         eq_in = (node_dist == slot_dist);
      end
   end

   always_comb begin
      if (scan_in.found) begin
         scan_out = scan_in;
         pos_out  = pos_in;
      end else begin
         scan_out.found = hit;
         scan_out.dup   = hit && occ && eq_ff;
         pos_out        = IDX_W'(CELL_IDX);
      end
   end

   always_comb begin
      slot_in = slot_ff;
      case (op)
         OP_INSERT: begin
            if (scan_in.found) begin
               slot_in = prev_entry;
            end else if (hit) begin
               slot_in = node;
            end
         end
         OP_ROTATE: slot_in = next_entry;
         default:   slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      lt_ff   <= lt_in;
      eq_ff   <= eq_in;
   end

   assign entry = slot_ff;

endmodule

// ===== rtl/xor_closest_node_list.sv =====
// Top level of the XOR-closest node list: control, result register and the chain of slots.
//
// Keeps up to LIST_DEPTH peers sorted by XOR distance of their id to the target id.
// req channel: one beat per command (clear, offer node, dump). req_stall is high
// while a command is in progress; the block works on one command at a time.
// rsp channel: result beats from a single output register; last marks the
// final beat of a command. csr port: write target_hi/mid/lo while idle.
// Clear, offer, unused modes and a dump of an empty list: the request is registered,
// the slots compare in ST_CMP and ST_EXEC registers the result once the output
// register is free, then returns to idle for the next request. The offered id is
// compared in every slot at once; the first empty, nearer or equal slot decides the outcome.
// Dump: while the output register is free, the chain rotates one slot per cycle
// towards its head, LIST_DEPTH steps in all. After ST_CMP and ST_EXEC the entries
// are registered from ST_DUMP, and the next request is taken once the rotation, held
// by an rsp stall, ends; entries are sent from the head slot, nearest first, at most eight.
// Reset clears the fill count, the control state and rsp_valid; the target
// registers return to zero. A stalled rsp beat holds, and the control waits
// for the output register to free before it commits the next result.
module xor_closest_node_list
   import xcnl_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int DUMP_W = (CNT_W > 4) ? CNT_W : 4;

   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] rot_ff, rot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [63:0]      target_hi_ff, target_mid_ff;
   logic [31:0]      target_lo_ff;

   logic [TARGET_W-1:0] target;
   entry_type           node;
   cell_op_type         cell_op;
   logic                out_free;
   logic                load_rsp;
   logic                req_accept;
   logic [DUMP_W-1:0]   fill_wide, dump_n, rot_wide;
   logic                dump_emit, dump_step, dump_end;

   scan_type         scan [LIST_DEPTH+1];
   logic [IDX_W-1:0] pos  [LIST_DEPTH+1];
   entry_type        ent  [LIST_DEPTH];
   logic             occ  [LIST_DEPTH];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign target = {target_hi_ff, target_mid_ff, target_lo_ff};
   assign node   = '{id_hi: req_ff.node_id_hi, id_mid: req_ff.node_id_mid,
                     id_lo: req_ff.node_id_lo, addr: req_ff.node_addr,
                     port: req_ff.node_port};

   assign fill_wide = DUMP_W'(fill_ff);
   assign dump_n    = (fill_wide > DUMP_W'(DUMP_MAX)) ? DUMP_W'(DUMP_MAX) : fill_wide;
   assign rot_wide  = DUMP_W'(rot_ff);
   assign dump_emit = rot_wide < dump_n;
   assign dump_step = !dump_emit || out_free;
   assign dump_end  = (rot_ff == IDX_W'(LIST_DEPTH - 1));

   // chain of slots
   assign scan[0] = '0;
   assign pos[0]  = '0;

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      assign occ[g] = fill_ff > CNT_W'(g);
      xcnl_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .target     (target),
         .node       (node),
         .occ        (occ[g]),
         .prev_entry ((g == 0) ? node : ent[(g == 0) ? 0 : g - 1]),
         .next_entry (ent[(g + 1) % LIST_DEPTH]),
         .scan_in    (scan[g]),
         .pos_in     (pos[g]),
         .scan_out   (scan[g+1]),
         .pos_out    (pos[g+1]),
         .entry      (ent[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: state_in = ST_EXEC;
         ST_EXEC: begin
            if (req_ff.mode == MODE_DUMP && fill_ff != '0) begin
               state_in = ST_DUMP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (dump_step && dump_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      cell_op  = OP_HOLD;
      load_rsp = 1'b0;
      fill_in  = fill_ff;
      rot_in   = rot_ff;
      rsp_in   = '0;
      rsp_in.kind   = KIND_STATUS;
      rsp_in.status = STAT_DONE;
      rsp_in.count  = 4'(fill_ff);
      rsp_in.last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: ;
         ST_CMP:  cell_op = OP_CMP;
         ST_EXEC: begin
            if (req_ff.mode == MODE_DUMP && fill_ff != '0) begin
               rot_in = '0;
            end else if (out_free) begin
               load_rsp = 1'b1;
               case (req_ff.mode)
                  MODE_CLEAR: begin
                     fill_in      = '0;
                     rsp_in.count = 4'd0;
                  end
                  MODE_OFFER: begin
                     if (req_ff.fail_count > NODE_FAIL_LIMIT) begin
                        rsp_in.status = STAT_BAD_NODE;
                     end else if (!scan[LIST_DEPTH].found) begin
                        rsp_in.status = STAT_TOO_FAR;
                     end else if (scan[LIST_DEPTH].dup) begin
                        rsp_in.status   = STAT_DUPLICATE;
                        rsp_in.position = 3'(pos[LIST_DEPTH]);
                     end else begin
                        cell_op = OP_INSERT;
                        if (fill_ff != CNT_W'(LIST_DEPTH)) begin
                           fill_in = fill_ff + CNT_W'(1);
                        end
                        rsp_in.status   = STAT_INSERTED;
                        rsp_in.position = 3'(pos[LIST_DEPTH]);
                        rsp_in.count    = 4'(fill_in);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DUMP: begin
            if (dump_step) begin
               cell_op = OP_ROTATE;
               rot_in  = rot_ff + IDX_W'(1);
               if (dump_emit) begin
                  load_rsp            = 1'b1;
                  rsp_in.kind         = KIND_ENTRY;
                  rsp_in.status       = STAT_INSERTED;
                  rsp_in.position     = 3'(rot_wide);
                  rsp_in.entry_id_hi  = ent[0].id_hi;
                  rsp_in.entry_id_mid = ent[0].id_mid;
                  rsp_in.entry_id_lo  = ent[0].id_lo;
                  rsp_in.entry_addr   = ent[0].addr;
                  rsp_in.entry_port   = ent[0].port;
                  rsp_in.last         = (rot_wide + DUMP_W'(1)) == dump_n;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rot_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         target_hi_ff  <= '0;
         target_mid_ff <= '0;
         target_lo_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TARGET_HI:  target_hi_ff  <= csr_wr_data;
               CSR_TARGET_MID: target_mid_ff <= csr_wr_data;
               CSR_TARGET_LO:  target_lo_ff  <= csr_wr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/xcnl_checker.sv =====
// Port-level checks for the XOR-closest node list, bound to the top level.
module xcnl_checker
   import xcnl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a command is in progress");

   // no new request while a dump is still streaming
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("request open during a dump");

   // idle and empty output after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind xor_closest_node_list xcnl_checker u_checker (.*);

// ===== sim/xor_closest_node_list_tb.sv =====
// Self-checking testbench for the XOR-closest node list: directed and random commands.
`timescale 1ns / 1ps

module xor_closest_node_list_tb;
   import xcnl_pkg::*;

   localparam int          DEPTH        = DEF_LIST_DEPTH;
   localparam int          DRAIN_CYCLES = 2 * (2 + DEPTH) + 10;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          LONG_HOLD    = 80;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_index   = CSR_TARGET_HI;
   logic [63:0] csr_wr_data = '0;

   // list state as the block should hold it
   entry_type    peer_slots[DEPTH];
   int unsigned  peer_count = 0;
   logic [159:0] target_id  = '0;

   req_type      queued_cmds[$];
   rsp_type      awaited_results[$];
   logic [159:0] offered_ids[$];

   int unsigned  cmds_queued  = 0;
   int unsigned  beats_sent   = 0;
   int unsigned  results_seen = 0;
   int unsigned  mismatches   = 0;
   int unsigned  cycle_count  = 0;
   int unsigned  req_gap      = 0;
   int unsigned  rsp_gap      = 0;
   int unsigned  hold_left    = 0;
   bit           hold_done    = 1'b0;
   bit           calm         = 1'b0;

   xor_closest_node_list i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_status(input logic [2:0] status, input int unsigned pos);
      rsp_type r;
      r          = '0;
      r.kind     = KIND_STATUS;
      r.status   = status;
      r.position = pos[2:0];
      r.count    = peer_count[3:0];
      r.last     = 1'b1;
      awaited_results.push_back(r);
   endfunction

   // Apply one command to the list and queue the results it should produce.
   function automatic void update_peer_list(input req_type c);
      rsp_type      r;
      logic [159:0] id;
      logic [159:0] slot_id;
      int unsigned  i;
      int unsigned  n;
      id = {c.node_id_hi, c.node_id_mid, c.node_id_lo};
      case (c.mode)
         MODE_CLEAR: begin
            peer_count = 0;
            push_status(STAT_DONE, 0);
         end
         MODE_DUMP: begin
            n = (peer_count < DUMP_MAX) ? peer_count : DUMP_MAX;
            if (n == 0) begin
               push_status(STAT_DONE, 0);
            end else begin
               for (i = 0; i < n; i++) begin
                  r              = '0;
                  r.kind         = KIND_ENTRY;
                  r.status       = STAT_INSERTED;
                  r.position     = i[2:0];
                  r.count        = peer_count[3:0];
                  r.entry_id_hi  = peer_slots[i].id_hi;
                  r.entry_id_mid = peer_slots[i].id_mid;
                  r.entry_id_lo  = peer_slots[i].id_lo;
                  r.entry_addr   = peer_slots[i].addr;
                  r.entry_port   = peer_slots[i].port;
                  r.last         = (i + 1 == n);
                  awaited_results.push_back(r);
               end
            end
         end
         MODE_OFFER: begin
            if (c.fail_count > NODE_FAIL_LIMIT) begin
               push_status(STAT_BAD_NODE, 0);
               return;
            end
            for (i = 0; i < peer_count; i++) begin
               slot_id = {peer_slots[i].id_hi, peer_slots[i].id_mid, peer_slots[i].id_lo};
               if (slot_id == id) begin
                  push_status(STAT_DUPLICATE, i);
                  return;
               end
               if ((id ^ target_id) < (slot_id ^ target_id))
                  break;
            end
            if (i >= DEPTH) begin
               push_status(STAT_TOO_FAR, 0);
               return;
            end
            if (peer_count < DEPTH)
               peer_count++;
            for (n = peer_count - 1; n > i; n--)
               peer_slots[n] = peer_slots[n - 1];
            peer_slots[i] = {c.node_id_hi, c.node_id_mid, c.node_id_lo, c.node_addr,
                             c.node_port};
            push_status(STAT_INSERTED, i);
         end
         default: begin
            push_status(STAT_DONE, 0);
         end
      endcase
   endfunction

   function automatic req_type make_cmd(input logic [1:0] mode, input logic [159:0] id,
                                        input logic [31:0] addr, input logic [15:0] port,
                                        input logic [7:0] fails);
      req_type c;
      c.mode = mode;
      {c.node_id_hi, c.node_id_mid, c.node_id_lo} = id;
      c.node_addr  = addr;
      c.node_port  = port;
      c.fail_count = fails;
      return c;
   endfunction

   // Mostly offers, so the list fills between clears; ids are fresh, near the
   // target or reused to hit duplicates.
   function automatic req_type random_cmd();
      req_type      c;
      logic [159:0] id;
      int unsigned  pick;
      id           = {$urandom, $urandom, $urandom, $urandom, $urandom};
      c            = make_cmd(MODE_OFFER, id, $urandom, 16'($urandom),
                              8'($urandom_range(0, 255)));
      pick         = $urandom_range(0, 99);
      if (pick < 4) begin
         c.mode = MODE_CLEAR;
      end else if (pick < 14) begin
         c.mode = MODE_DUMP;
      end else if (pick < 17) begin
         c.mode = MODE_UNUSED;
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            id = target_id ^ (id >> $urandom_range(100, 159));
         else if (pick < 6 && offered_ids.size() > 0)
            id = offered_ids[$urandom_range(0, offered_ids.size() - 1)];
         {c.node_id_hi, c.node_id_mid, c.node_id_lo} = id;
         if ($urandom_range(0, 6) != 0)
            c.fail_count = 8'($urandom_range(0, NODE_FAIL_LIMIT));
         offered_ids.push_back(id);
         if (offered_ids.size() > 24)
            void'(offered_ids.pop_front());
      end
      return c;
   endfunction

   task automatic queue_cmd(input req_type c);
      queued_cmds.push_back(c);
      cmds_queued++;
   endtask

   task automatic write_target(input logic [63:0] hi, input logic [63:0] mid,
                               input logic [63:0] lo);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_TARGET_HI;
      csr_wr_data <= hi;
      @(posedge clock);
      csr_index   <= CSR_TARGET_MID;
      csr_wr_data <= mid;
      @(posedge clock);
      csr_index   <= CSR_TARGET_LO;
      csr_wr_data <= lo;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      target_id = {hi, mid, lo[31:0]};
   endtask

   // wait until every queued command is sent and answered, then let the block drain
   task automatic settle();
      while (beats_sent != cmds_queued || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input logic [63:0] hi, input logic [63:0] mid,
                                   input logic [63:0] lo, input int unsigned n);
      settle();
      write_target(hi, mid, lo);
      repeat (n) queue_cmd(random_cmd());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_target('0, '0, '0);

      // directed: target zero, so distance equals the id
      queue_cmd(make_cmd(MODE_DUMP, '0, '0, '0, '0));
      queue_cmd(make_cmd(MODE_OFFER, 160'd1, 32'h0a000001, 16'd80, 8'd3));
      queue_cmd(make_cmd(MODE_OFFER, 160'd2, 32'h0a000002, 16'd81, 8'hff));
      queue_cmd(make_cmd(MODE_OFFER, '0, '1, '1, 8'd0));
      queue_cmd(make_cmd(MODE_OFFER, '1, '0, '0, 8'd2));
      queue_cmd(make_cmd(MODE_OFFER, '0, 32'h01020304, 16'd7, 8'd0));
      for (int k = 1; k <= 6; k++)
         queue_cmd(make_cmd(MODE_OFFER, {64'(k), 64'(k), 32'(k)}, $urandom, 16'($urandom),
                            8'd1));
      queue_cmd(make_cmd(MODE_OFFER, {64'd3, 64'd3, 32'd3}, '1, '1, 8'd0));
      queue_cmd(make_cmd(MODE_OFFER, {{128{1'b1}}, 32'hffff_fffe}, $urandom, 16'($urandom),
                         8'd0));
      queue_cmd(make_cmd(MODE_OFFER, '1, $urandom, 16'($urandom), 8'd0));
      queue_cmd(make_cmd(MODE_OFFER, 160'd5, $urandom, 16'($urandom), 8'd2));
      queue_cmd(make_cmd(MODE_DUMP, '0, '0, '0, '0));
      queue_cmd(make_cmd(MODE_UNUSED, '0, '0, '0, '0));
      queue_cmd(make_cmd(MODE_CLEAR, '1, '1, '1, '1));
      queue_cmd(make_cmd(MODE_DUMP, '1, '1, '1, '1));
      queue_cmd(make_cmd(MODE_UNUSED, '1, '1, '1, '1));

      run_random_phase('1, '1, '1, 40);
      run_random_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 40);
      run_random_phase({$urandom, $urandom}, '0, '1, 40);
      settle();
      calm = 1'b1;
      write_target({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      repeat (40) queue_cmd(random_cmd());
      settle();

      if (mismatches == 0 && awaited_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_peer_list(req_data);
            beats_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
               req_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (queued_cmds.size() > 0) begin
               req_data  <= queued_cmds.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long hold so the block backs up onto its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && results_seen >= 30) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %0d: %h", results_seen, rsp_data);
            end else begin
               exp = awaited_results.pop_front();
               if (rsp_data !== exp) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("beat %0d exp: kind %0d st %0d pos %0d cnt %0d last %0d id %h %h %h addr %h port %h",
                              results_seen, exp.kind, exp.status, exp.position, exp.count,
                              exp.last, exp.entry_id_hi, exp.entry_id_mid, exp.entry_id_lo,
                              exp.entry_addr, exp.entry_port);
                     $display("beat %0d got: kind %0d st %0d pos %0d cnt %0d last %0d id %h %h %h addr %h port %h",
                              results_seen, rsp_data.kind, rsp_data.status, rsp_data.position,
                              rsp_data.count, rsp_data.last, rsp_data.entry_id_hi,
                              rsp_data.entry_id_mid, rsp_data.entry_id_lo, rsp_data.entry_addr,
                              rsp_data.entry_port);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
